// ===== hdl/cnmd_pkg.sv =====
// shared types, constants and functions of the crossing number minutiae detector
package cnmd_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int LINE_AW   = $clog2(MAX_WIDTH);
  localparam int COL_W     = 11;
  localparam int ROW_W     = 12;
  localparam int DIM_W     = 12;
  localparam int PIX_W     = 8;
  localparam int CN_W      = 3;
  localparam int WIN_W     = 9;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [CN_W-1:0]  TARGET_RST = 3'd1;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [DIM_W-1:0] MIN_DIM    = 12'd3;

  typedef struct packed {
    logic [WIN_W-1:0] win;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } win_req_t;

  typedef struct packed {
    logic     valid;
    win_req_t data;
  } push_req_t;

  typedef struct packed {
    logic              not_empty;
    logic [QCNT_W-1:0] level;
  } q_stat_t;

  function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] w);
    logic [DIM_W-1:0] res;
    res = w;
    if (w < MIN_DIM) res = MIN_DIM;
    if (w > DIM_W'(MAX_WIDTH)) res = DIM_W'(MAX_WIDTH);
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] h);
    return (h < MIN_DIM) ? MIN_DIM : h;
  endfunction

  // ring order tl, t, tr, r, br, b, bl, l; window bit index is col*3 + row
  function automatic logic [CN_W-1:0] crossing_num(input logic [WIN_W-1:0] w);
    logic [7:0] ring;
    logic [7:0] diff;
    logic [3:0] sum;
    ring = {w[1], w[2], w[5], w[8], w[7], w[6], w[3], w[0]};
    diff = ring ^ {ring[0], ring[7:1]};
    sum  = 4'd0;
    for (int k = 0; k < 8; k++) begin
      sum = sum + {3'd0, diff[k]};
    end
    return sum[3:1];
  endfunction

endpackage

// ===== hdl/cnmd_front.sv =====
// front end: raster position, line store, 3x3 window and request push
module cnmd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cnmd_pkg::PIX_W-1:0]   in_pixel,
  input  logic [cnmd_pkg::DIM_W-1:0]   image_width,
  input  logic [cnmd_pkg::DIM_W-1:0]   image_height,
  input  cnmd_pkg::q_stat_t            q_stat,
  output cnmd_pkg::push_req_t          push
);

  logic                           clr_busy_r;
  logic [cnmd_pkg::LINE_AW-1:0]   clr_addr_r;
  logic [cnmd_pkg::COL_W-1:0]     col_r;
  logic [cnmd_pkg::ROW_W-1:0]     row_r;
  logic                           b_valid_r;
  logic                           b_bit_r;
  logic [cnmd_pkg::COL_W-1:0]     b_c_r;
  logic [cnmd_pkg::ROW_W-1:0]     b_r_r;
  logic [1:0]                     rd_data_r;
  logic [cnmd_pkg::WIN_W-1:0]     win_r;
  logic [cnmd_pkg::WIN_W-1:0]     win_nxt;
  logic [1:0]                     line_mem [cnmd_pkg::MAX_WIDTH];

  logic                           accept;
  logic [cnmd_pkg::DIM_W-1:0]     w_eff;
  logic [cnmd_pkg::DIM_W-1:0]     h_eff;
  logic [cnmd_pkg::COL_W-1:0]     c;
  logic [cnmd_pkg::ROW_W-1:0]     r;
  logic [cnmd_pkg::DIM_W:0]       c_inc;
  logic [cnmd_pkg::DIM_W:0]       r_inc;
  logic [cnmd_pkg::QCNT_W-1:0]    in_flight;
  logic                           we;
  logic [cnmd_pkg::LINE_AW-1:0]   wa;
  logic [1:0]                     wd;
  logic                           emit;

  assign w_eff = cnmd_pkg::eff_width(image_width);
  assign h_eff = cnmd_pkg::eff_height(image_height);

  assign c = ({1'b0, col_r} >= w_eff) ? cnmd_pkg::COL_W'(w_eff - 1'b1) : col_r;
  assign r = (row_r >= h_eff) ? (h_eff - 1'b1) : row_r;
  assign c_inc = {2'b00, c} + 1'b1;
  assign r_inc = {1'b0, r} + 1'b1;

  assign in_flight = q_stat.level + {{(cnmd_pkg::QCNT_W-1){1'b0}}, b_valid_r};
  assign in_stall  = clr_busy_r || (in_flight >= cnmd_pkg::QCNT_W'(cnmd_pkg::QDEPTH));
  assign accept    = in_valid && !in_stall;

  // line store word: bit 1 row above, bit 0 two rows above
  always_comb begin
    if (clr_busy_r) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = 2'b00;
    end else begin
      we = b_valid_r;
      wa = cnmd_pkg::LINE_AW'(b_c_r);
      wd = {b_bit_r, rd_data_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      line_mem[wa] <= wd;
    end
    if (accept) begin
      rd_data_r <= line_mem[cnmd_pkg::LINE_AW'(c)];
    end
  end

  assign win_nxt = {b_bit_r, rd_data_r[1], rd_data_r[0], win_r[8:3]};
  assign emit    = b_valid_r && (b_c_r >= cnmd_pkg::COL_W'(2)) && (b_r_r >= cnmd_pkg::ROW_W'(2));

  always_comb begin
    push.valid    = emit;
    push.data.win = win_nxt;
    push.data.row = b_r_r - 1'b1;
    push.data.col = b_c_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
      b_valid_r  <= 1'b0;
      win_r      <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == cnmd_pkg::LINE_AW'(cnmd_pkg::MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      b_valid_r <= accept;
      if (accept) begin
        if (c_inc >= {1'b0, w_eff}) begin
          col_r <= '0;
          row_r <= (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[cnmd_pkg::ROW_W-1:0];
        end else begin
          col_r <= c_inc[cnmd_pkg::COL_W-1:0];
          row_r <= r;
        end
      end
      if (b_valid_r) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_bit_r <= (in_pixel == '0);
      b_c_r   <= c;
      b_r_r   <= r;
    end
  end

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !accept) else $error("request taken during line store clear");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (q_stat.level < cnmd_pkg::QCNT_W'(cnmd_pkg::QDEPTH)))
    else $error("push with no room in queue");
`endif

endmodule

// ===== hdl/cnmd_queue.sv =====
// short queue of window requests between front and back
module cnmd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cnmd_pkg::push_req_t   push,
  input  logic                  pop,
  output cnmd_pkg::win_req_t    head,
  output cnmd_pkg::q_stat_t     q_stat
);

  cnmd_pkg::win_req_t            q_mem_r [cnmd_pkg::QDEPTH];
  logic [cnmd_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [cnmd_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [cnmd_pkg::QCNT_W-1:0]   count_r;
  logic                          do_pop;

  assign do_pop           = pop && (count_r != '0);
  assign head             = q_mem_r[rd_ptr_r];
  assign q_stat.not_empty = (count_r != '0);
  assign q_stat.level     = count_r;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_mem_r[wr_ptr_r] <= push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push.valid, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnmd_pkg::QCNT_W'(cnmd_pkg::QDEPTH)) else $error("queue overflow");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !push.valid) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count lost a pop");
`endif

endmodule

// ===== hdl/cnmd_back.sv =====
// back end: crossing number, minutia mark and output register
module cnmd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cnmd_pkg::q_stat_t           q_stat,
  input  cnmd_pkg::win_req_t          head,
  output logic                        pop,
  input  logic [cnmd_pkg::CN_W-1:0]   target_crossing,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cnmd_pkg::ROW_W-1:0]  out_center_row,
  output logic [cnmd_pkg::COL_W-1:0]  out_center_col,
  output logic [cnmd_pkg::CN_W-1:0]   out_crossing,
  output logic                        out_is_minutia
);

  logic                        out_valid_r;
  logic [cnmd_pkg::ROW_W-1:0]  row_r;
  logic [cnmd_pkg::COL_W-1:0]  col_r;
  logic [cnmd_pkg::CN_W-1:0]   cn_r;
  logic                        mark_r;
  logic [cnmd_pkg::CN_W-1:0]   cn;

  assign cn  = cnmd_pkg::crossing_num(head.win);
  assign pop = q_stat.not_empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= q_stat.not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_r  <= head.row;
      col_r  <= head.col;
      cn_r   <= cn;
      mark_r <= head.win[4] && (cn == target_crossing);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_center_row = row_r;
  assign out_center_col = col_r;
  assign out_crossing   = cn_r;
  assign out_is_minutia = mark_r;

`ifndef SYNTH
  a_cn_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cn_r <= cnmd_pkg::CN_W'(4))) else $error("crossing number out of range");
`endif

endmodule

// ===== hdl/crossing_number_minutiae_detect_core.sv =====
// top level: configuration registers and front, queue and back of the minutiae detector
// Takes one skeleton pixel per cycle in raster order while in_stall is low and returns
// one request per interior pixel with its row, column, crossing number and minutia mark,
// in pixel order; results start at the third pixel of the third row of the frame. An item
// passes the position counters and line store read, then the store write and window
// shift, then the four-entry queue and the crossing unit into the output register, where
// out_stall can hold it back in the queue; the sustained rate is one pixel per cycle while
// nothing stalls, limited by the single write port of the line store. After reset the
// line store is cleared one entry a cycle, during which in_stall is high; register
// writes are taken throughout. Registers at byte addresses 0 target crossing, 4
// image width, 8 image height; write them only while no pixel is in flight.
module crossing_number_minutiae_detect_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cnmd_pkg::PIX_W-1:0]    in_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cnmd_pkg::ROW_W-1:0]    out_center_row,
  output logic [cnmd_pkg::COL_W-1:0]    out_center_col,
  output logic [cnmd_pkg::CN_W-1:0]     out_crossing,
  output logic                          out_is_minutia,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cnmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [cnmd_pkg::PDATA_W-1:0]  pwdata,
  output logic [cnmd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [cnmd_pkg::CN_W-1:0]   target_r;
  logic [cnmd_pkg::DIM_W-1:0]  width_r;
  logic [cnmd_pkg::DIM_W-1:0]  height_r;
  logic                        wr_en;
  logic [1:0]                  reg_idx;
  cnmd_pkg::push_req_t         push;
  cnmd_pkg::q_stat_t           q_stat;
  cnmd_pkg::win_req_t          head;
  logic                        pop;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= cnmd_pkg::TARGET_RST;
      width_r  <= cnmd_pkg::WIDTH_RST;
      height_r <= cnmd_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        cnmd_pkg::REG_TARGET: target_r <= pwdata[cnmd_pkg::CN_W-1:0];
        cnmd_pkg::REG_WIDTH:  width_r  <= pwdata[cnmd_pkg::DIM_W-1:0];
        cnmd_pkg::REG_HEIGHT: height_r <= pwdata[cnmd_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cnmd_pkg::REG_TARGET: prdata = cnmd_pkg::PDATA_W'(target_r);
      cnmd_pkg::REG_WIDTH:  prdata = cnmd_pkg::PDATA_W'(width_r);
      cnmd_pkg::REG_HEIGHT: prdata = cnmd_pkg::PDATA_W'(height_r);
      default:              prdata = '0;
    endcase
  end

  cnmd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel     (in_pixel),
    .image_width  (width_r),
    .image_height (height_r),
    .q_stat       (q_stat),
    .push         (push)
  );

  cnmd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  cnmd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head            (head),
    .pop             (pop),
    .target_crossing (target_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_center_row  (out_center_row),
    .out_center_col  (out_center_col),
    .out_crossing    (out_crossing),
    .out_is_minutia  (out_is_minutia)
  );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of the crossing number minutiae detector core
module testbench;

  localparam logic [71:0] ENDING_FRAME   = {8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255,
                                            8'd255, 8'd255, 8'd255};
  localparam logic [71:0] ISOLATED_FRAME = {8'd1, 8'd128, 8'd64, 8'd32, 8'd0, 8'd16,
                                            8'd8, 8'd4, 8'd2};
  localparam logic [71:0] CHECKER_FRAME  = {8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
                                            8'd0, 8'd255, 8'd0};

  typedef struct {
    logic [cnmd_pkg::ROW_W-1:0] row;
    logic [cnmd_pkg::COL_W-1:0] col;
    logic [cnmd_pkg::CN_W-1:0]  crossing;
    logic                       is_minutia;
  } centre_t;

  class centre_scoreboard;
    logic [cnmd_pkg::CN_W-1:0]  target;
    logic [cnmd_pkg::DIM_W-1:0] width_reg;
    logic [cnmd_pkg::DIM_W-1:0] height_reg;
    bit                         line_above[cnmd_pkg::MAX_WIDTH];
    bit                         line_two_above[cnmd_pkg::MAX_WIDTH];
    logic [cnmd_pkg::WIN_W-1:0] window;
    int unsigned                col_count;
    int unsigned                row_count;
    centre_t                    pending[$];
    int                         errors;

    function new();
      target     = cnmd_pkg::TARGET_RST;
      width_reg  = cnmd_pkg::WIDTH_RST;
      height_reg = cnmd_pkg::HEIGHT_RST;
      window     = '0;
      col_count  = 0;
      row_count  = 0;
      errors     = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function void set_register(input logic [1:0] idx,
                               input logic [cnmd_pkg::PDATA_W-1:0] value);
      case (idx)
        cnmd_pkg::REG_TARGET: target = value[cnmd_pkg::CN_W-1:0];
        cnmd_pkg::REG_WIDTH:  width_reg = value[cnmd_pkg::DIM_W-1:0];
        cnmd_pkg::REG_HEIGHT: height_reg = value[cnmd_pkg::DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [cnmd_pkg::PDATA_W-1:0] register_value(input logic [1:0] idx);
      case (idx)
        cnmd_pkg::REG_TARGET: return cnmd_pkg::PDATA_W'(target);
        cnmd_pkg::REG_WIDTH:  return cnmd_pkg::PDATA_W'(width_reg);
        cnmd_pkg::REG_HEIGHT: return cnmd_pkg::PDATA_W'(height_reg);
        default:              return '0;
      endcase
    endfunction

    // shifts the pixel into the window and queues the centre it completes, if interior
    function void note_pixel(input logic [cnmd_pkg::PIX_W-1:0] pixel);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned changes;
      bit          ridge;
      bit [7:0]    ring;
      centre_t     due;
      w = (width_reg < 3) ? 3 : ((width_reg > cnmd_pkg::MAX_WIDTH) ? cnmd_pkg::MAX_WIDTH
                                                                     : width_reg);
      h = (height_reg < 3) ? 3 : height_reg;
      c = (col_count < w) ? col_count : w - 1;
      r = (row_count < h) ? row_count : h - 1;
      ridge = (pixel == '0);
      window = {ridge, line_above[c], line_two_above[c], window[8:3]};
      line_two_above[c] = line_above[c];
      line_above[c] = ridge;
      if (c >= 2 && r >= 2) begin
        // ring walk tl, t, tr, r, br, b, bl, l; window bit is col*3 + row
        ring[0] = window[0];
        ring[1] = window[3];
        ring[2] = window[6];
        ring[3] = window[7];
        ring[4] = window[8];
        ring[5] = window[5];
        ring[6] = window[2];
        ring[7] = window[1];
        changes = 0;
        for (int k = 0; k < 8; k++) changes += ring[k] ^ ring[(k + 1) % 8];
        due.row        = cnmd_pkg::ROW_W'(r - 1);
        due.col        = cnmd_pkg::COL_W'(c - 1);
        due.crossing   = cnmd_pkg::CN_W'(changes / 2);
        due.is_minutia = window[4] && ((changes / 2) == target);
        pending.push_back(due);
      end
      if (c + 1 >= w) begin
        col_count = 0;
        row_count = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_count = c + 1;
        row_count = r;
      end
    endfunction

    task check_centre(input logic [cnmd_pkg::ROW_W-1:0] row,
                      input logic [cnmd_pkg::COL_W-1:0] col,
                      input logic [cnmd_pkg::CN_W-1:0] crossing, input logic is_minutia);
      centre_t due;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result row %0d col %0d", row, col));
        return;
      end
      due = pending.pop_front();
      if (row !== due.row)
        report($sformatf("row %0d, expected %0d", row, due.row));
      if (col !== due.col)
        report($sformatf("col %0d, expected %0d (row %0d)", col, due.col, due.row));
      if (crossing !== due.crossing)
        report($sformatf("crossing %0d, expected %0d at %0d/%0d", crossing, due.crossing,
                         due.row, due.col));
      if (is_minutia !== due.is_minutia)
        report($sformatf("mark %0b, expected %0b at %0d/%0d", is_minutia, due.is_minutia,
                         due.row, due.col));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [cnmd_pkg::PIX_W-1:0]   in_pixel;
  logic                         out_valid;
  logic                         out_stall;
  logic [cnmd_pkg::ROW_W-1:0]   out_center_row;
  logic [cnmd_pkg::COL_W-1:0]   out_center_col;
  logic [cnmd_pkg::CN_W-1:0]    out_crossing;
  logic                         out_is_minutia;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [cnmd_pkg::PADDR_W-1:0] paddr;
  logic [cnmd_pkg::PDATA_W-1:0] pwdata;
  logic [cnmd_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  bit                 steady;
  int                 random_items;
  centre_scoreboard   sb;

  crossing_number_minutiae_detect_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_center_row (out_center_row),
    .out_center_col (out_center_col),
    .out_crossing   (out_crossing),
    .out_is_minutia (out_is_minutia),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_centre(out_center_row, out_center_col, out_crossing, out_is_minutia);
  end

  function automatic logic [cnmd_pkg::PIX_W-1:0] random_pixel();
    if ($urandom_range(99) < 48) return '0;
    return cnmd_pkg::PIX_W'($urandom_range(255, 1));
  endfunction

  task automatic send_pixel(input logic [cnmd_pkg::PIX_W-1:0] pixel);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pixel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(pixel);
  endtask

  task automatic send_frame(input logic [71:0] frame);
    for (int k = 0; k < 9; k++) send_pixel(frame[71 - 8 * k -: 8]);
  endtask

  task automatic wait_results(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    if (settle) repeat (8) @(posedge clk);
  endtask

  // write followed by a read-back of the same register
  task automatic write_register(input logic [1:0] idx,
                                input logic [cnmd_pkg::PDATA_W-1:0] value);
    logic [cnmd_pkg::PDATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== sb.register_value(idx))
      sb.report($sformatf("register %0d reads %0h, expected %0h", idx, readback,
                          sb.register_value(idx)));
  endtask

  task automatic configure(input int target, input int w, input int h);
    wait_results(1'b1);
    write_register(cnmd_pkg::REG_TARGET, cnmd_pkg::PDATA_W'(target));
    write_register(cnmd_pkg::REG_WIDTH, cnmd_pkg::PDATA_W'(w));
    write_register(cnmd_pkg::REG_HEIGHT, cnmd_pkg::PDATA_W'(h));
  endtask

  initial begin
    int phase;
    int count;
    int w;
    int h;
    int t;
    sb           = new();
    steady       = 1'b0;
    random_items = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_pixel  <= '0;
    out_stall <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ridge ending, isolated point with undersized frame, full crossing of four
    configure(1, 3, 3);
    send_frame(ENDING_FRAME);
    configure(0, 1, 0);
    send_frame(ISOLATED_FRAME);
    configure(4, 2, 1);
    send_frame(CHECKER_FRAME);

    phase = 0;
    while (random_items < 1000) begin
      steady = (phase >= 6 && phase < 9);
      if (phase == 4) begin
        // widest line store, width register saturating
        configure(3, 4095, 3);
        count = 96;
      end else begin
        t = ($urandom_range(3) == 0) ? $urandom_range(7, 5) : $urandom_range(4, 0);
        case ($urandom_range(9))
          0:       w = $urandom_range(2, 0);
          1:       w = $urandom_range(80, 25);
          default: w = $urandom_range(16, 3);
        endcase
        case ($urandom_range(9))
          0:       h = $urandom_range(2, 0);
          1:       h = 4095;
          default: h = $urandom_range(8, 3);
        endcase
        configure(t, w, h);
        count = $urandom_range(120, 30);
      end
      for (int k = 0; k < count; k++) begin
        if (phase == 2 && k == count / 2) wait_results(1'b0);
        send_pixel(random_pixel());
      end
      random_items += count;
      phase++;
    end
    steady = 1'b0;

    wait_results(1'b1);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
